FILE: rtl/lpfs_pkg.sv
// Shared types, constants and the charlieplex line table of the LED frame scheduler.
`timescale 1ns / 1ps

package lpfs_pkg;

	localparam int FRAME_UNIT      = 10;
	localparam int LINE_TABLE_SIZE = 31;
	localparam int SLOT_TIME_W     = 10;

	localparam logic [4:0]  DEBUG_LED     = 5'd18;
	localparam logic [15:0] DARK_DURATION = 16'(1 << FRAME_UNIT);

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_FLUSH = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_FIN,
		ST_TICK,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [4:0] led_select;
		logic [7:0] brightness;
		logic [7:0] flush_count;
	} cmd_t;

	typedef struct packed {
		logic        led_on;
		logic [4:0]  lit_led;
		logic [2:0]  high_line;
		logic [2:0]  low_line;
		logic        low_line_used;
		logic [15:0] duration;
		logic        frame_start;
		logic        flush_accepted;
	} rsp_t;

	// One tick's slot as seen after the slot memory read.
	typedef struct packed {
		logic                   read;
		logic                   in_table;
		logic [4:0]             led;
		logic [SLOT_TIME_W-1:0] on_time;
		logic [15:0]            dflt;
		logic                   frame_start;
	} slot_view_t;

	// Returns {high line, low line} for an LED inside the table.
	function automatic logic [5:0] line_pair(input logic [4:0] led);
		logic [5:0] pair;
		case (led)
			5'd0:    pair = {3'd0, 3'd3};
			5'd1:    pair = {3'd1, 3'd3};
			5'd2:    pair = {3'd2, 3'd3};
			5'd3:    pair = {3'd3, 3'd0};
			5'd4:    pair = {3'd4, 3'd0};
			5'd5:    pair = {3'd5, 3'd0};
			5'd6:    pair = {3'd0, 3'd4};
			5'd7:    pair = {3'd1, 3'd4};
			5'd8:    pair = {3'd2, 3'd4};
			5'd9:    pair = {3'd3, 3'd1};
			5'd10:   pair = {3'd4, 3'd1};
			5'd11:   pair = {3'd5, 3'd1};
			5'd12:   pair = {3'd0, 3'd5};
			5'd13:   pair = {3'd1, 3'd5};
			5'd14:   pair = {3'd2, 3'd5};
			5'd15:   pair = {3'd3, 3'd2};
			5'd16:   pair = {3'd4, 3'd2};
			5'd17:   pair = {3'd5, 3'd2};
			5'd18:   pair = {3'd6, 3'd6};
			5'd19:   pair = {3'd1, 3'd0};
			5'd20:   pair = {3'd2, 3'd0};
			5'd21:   pair = {3'd0, 3'd1};
			5'd22:   pair = {3'd2, 3'd1};
			5'd23:   pair = {3'd0, 3'd2};
			5'd24:   pair = {3'd1, 3'd2};
			5'd25:   pair = {3'd4, 3'd3};
			5'd26:   pair = {3'd5, 3'd3};
			5'd27:   pair = {3'd3, 3'd4};
			5'd28:   pair = {3'd5, 3'd4};
			5'd29:   pair = {3'd3, 3'd5};
			5'd30:   pair = {3'd4, 3'd5};
			default: pair = 6'd0;
		endcase
		return pair;
	endfunction

endpackage

FILE: rtl/lpfs_slot_decode.sv
// Turns one slot memory entry into the tick result: LED, lines and slot length.
`timescale 1ns / 1ps

module lpfs_slot_decode
	import lpfs_pkg::*;
(
	input  slot_view_t view,
	output rsp_t       rsp
);

	logic [5:0] pair;

	assign pair = line_pair(view.led);

	always_comb begin
		rsp = '0;
		rsp.frame_start = view.frame_start;
		if (!view.read) begin
			rsp.duration = view.dflt;
		end else if (view.on_time == '0) begin
			// empty frame: dark slot of one frame unit
			rsp.duration = DARK_DURATION;
		end else begin
			rsp.led_on    = 1'b1;
			rsp.lit_led   = view.led;
			rsp.duration  = 16'(view.on_time);
			if (view.in_table) begin
				rsp.high_line = pair[5:3];
				if (view.led != DEBUG_LED) begin
					rsp.low_line      = pair[2:0];
					rsp.low_line_used = 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/led_pwm_frame_scheduler.sv
// Top level of the double-buffered LED frame scheduler.
`timescale 1ns / 1ps

// Every command word yields one response word. A brightness write or an unknown
// operation passes through the execute state to the response register, a timer
// tick first reads the slot memory, and a flush first walks the brightness memory
// at one entry per cycle with a three-stage read, square and write-back pipeline
// into the idle slot bank. A refused flush goes straight to the response. The
// brightness store and the two slot banks live in synchronous memories; reset is
// immediate, with per-entry valid bits on the brightness store and one valid bit
// per slot bank standing in for cleared contents. A new command is taken while a
// finished response still waits.

module led_pwm_frame_scheduler
	import lpfs_pkg::*;
#(
	parameter int NUM_LEDS = 31
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int BAW   = $clog2(NUM_LEDS);
	localparam int SAW   = $clog2(2 * NUM_LEDS);
	localparam int LED_W = (BAW > 5) ? BAW : 5;
	localparam int CNT_W = $clog2(NUM_LEDS + 1);
	localparam int POS_W = $clog2(NUM_LEDS + 2);
	localparam int SLW   = LED_W + SLOT_TIME_W;
	localparam logic [16:0]    OFF_LIMIT = 17'(NUM_LEDS * (1 << FRAME_UNIT));
	localparam logic [SAW-1:0] BANK1_BASE = SAW'(NUM_LEDS);

	state_t state_q, state_d;
	cmd_t   item_q;
	op_t    op;

	// brightness store
	logic [7:0]          bmem [NUM_LEDS];
	logic [NUM_LEDS-1:0] bvalid_q;
	logic [7:0]          bm_rd_q;
	logic                bm_we, bm_re;
	logic [BAW-1:0]      bm_waddr, bm_raddr;
	logic                sel_ok;

	// slot banks
	logic [SLW-1:0] smem [2 * NUM_LEDS];
	logic [SLW-1:0] smem_rd_q;
	logic           slot_we, slot_re;
	logic [SAW-1:0] slot_waddr, slot_raddr;
	logic [SLW-1:0] slot_wdata;

	logic [CNT_W-1:0] bank_cnt_q [2];
	logic [15:0]      bank_off_q [2];
	logic [1:0]       bank_ok_q;
	logic             live_q, pending_q;
	logic [POS_W-1:0] pos_q;

	// flush walk
	logic [POS_W-1:0]       walk_q;
	logic [CNT_W-1:0]       n_q;
	logic [15:0]            off_q;
	logic                   flush_bank_q;
	logic [SAW-1:0]         flush_base;
	logic                   v_s1, bval_s1;
	logic [BAW-1:0]         idx_s1;
	logic                   v_s2, nz_s2;
	logic [BAW-1:0]         idx_s2;
	logic [15:0]            sq_s2;
	logic [7:0]             b_s1;
	logic [SLOT_TIME_W-1:0] on_t;
	logic [7:0]             cnt_eff;
	logic [15:0]            off_fix;
	logic                   walk_done;

	// tick
	logic [CNT_W-1:0] cnt_live;
	logic             at_off, restart, swap, tick_bank;
	logic [POS_W-1:0] tick_pos;
	logic             tread_q, tok_q, tfs_q;
	logic [15:0]      tdflt_q;
	slot_view_t       view;
	rsp_t             dec_rsp;

	rsp_t res_q, rsp_q, taken_rsp;
	logic rsp_valid_q, rsp_free;

	assign op        = op_t'(item_q.operation);
	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	assign sel_ok   = (32'(item_q.led_select) < NUM_LEDS);
	assign bm_waddr = BAW'(item_q.led_select);
	assign bm_raddr = BAW'(walk_q);

	assign b_s1       = bval_s1 ? bm_rd_q : 8'd0;
	assign on_t       = sq_s2[15:6] + SLOT_TIME_W'(1);
	assign flush_base = flush_bank_q ? BANK1_BASE : '0;
	assign walk_done  = (walk_q == POS_W'(NUM_LEDS + 1));
	assign cnt_eff    = (item_q.flush_count == 8'd0) ? 8'd1 : item_q.flush_count;
	assign off_fix    = (({1'b0, off_q} > OFF_LIMIT) || (off_q == 16'd0)) ? 16'd1 : off_q;

	assign cnt_live  = bank_cnt_q[live_q];
	assign at_off    = (pos_q == POS_W'(cnt_live));
	assign restart   = (pos_q > POS_W'(cnt_live));
	assign swap      = restart && pending_q;
	assign tick_bank = live_q ^ swap;
	assign tick_pos  = restart ? '0 : pos_q;

	always_comb begin
		taken_rsp                = '0;
		taken_rsp.flush_accepted = 1'b1;
	end

	always_comb begin
		state_d    = state_q;
		bm_we      = 1'b0;
		bm_re      = 1'b0;
		slot_we    = 1'b0;
		slot_re    = 1'b0;
		slot_waddr = flush_base + SAW'(n_q);
		slot_wdata = {LED_W'(idx_s2), on_t};
		slot_raddr = (tick_bank ? BANK1_BASE : '0) + SAW'(tick_pos);
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (op)
					OP_WRITE: begin
						bm_we   = sel_ok;
						state_d = ST_RESP;
					end
					OP_FLUSH: state_d = pending_q ? ST_RESP : ST_WALK;
					OP_TICK: begin
						slot_re = 1'b1;
						state_d = ST_TICK;
					end
					default: state_d = ST_RESP;
				endcase
			end
			ST_WALK: begin
				bm_re   = (walk_q < POS_W'(NUM_LEDS));
				slot_we = v_s2 && nz_s2;
				if (walk_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				// no lit LED: one dark slot for the debug LED
				slot_we    = (n_q == '0);
				slot_waddr = flush_base;
				slot_wdata = {LED_W'(DEBUG_LED), SLOT_TIME_W'(0)};
				state_d    = ST_RESP;
			end
			ST_TICK: state_d = ST_RESP;
			ST_RESP: begin
				if (rsp_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// memories
	always_ff @(posedge clk) begin
		if (bm_we) bmem[bm_waddr] <= item_q.brightness;
		if (bm_re) bm_rd_q <= bmem[bm_raddr];
	end

	always_ff @(posedge clk) begin
		if (slot_we) smem[slot_waddr] <= slot_wdata;
		if (slot_re) smem_rd_q <= smem[slot_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q      <= '0;
			bank_cnt_q[0] <= CNT_W'(1);
			bank_cnt_q[1] <= CNT_W'(1);
			bank_off_q[0] <= 16'd1;
			bank_off_q[1] <= 16'd1;
			bank_ok_q     <= '0;
			live_q        <= 1'b0;
			pending_q     <= 1'b0;
			pos_q         <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			v_s1 <= bm_re;
			v_s2 <= v_s1;
			if (bm_we) bvalid_q[bm_waddr] <= 1'b1;
			// clear the store as the walk passes
			if (bm_re) bvalid_q[bm_raddr] <= 1'b0;
			if (state_q == ST_EXEC && op == OP_TICK) begin
				pos_q  <= tick_pos + POS_W'(1);
				live_q <= tick_bank;
				if (swap) pending_q <= 1'b0;
			end
			if (state_q == ST_FIN) begin
				bank_cnt_q[flush_bank_q] <= (n_q == '0) ? CNT_W'(1) : n_q;
				bank_off_q[flush_bank_q] <= (n_q == '0) ? DARK_DURATION : off_fix;
				bank_ok_q[flush_bank_q]  <= 1'b1;
				pending_q                <= 1'b1;
			end
			if (state_q == ST_RESP && rsp_free) rsp_valid_q <= 1'b1;
			else if (!rsp_stall)                rsp_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) item_q <= cmd;
		if (bm_re) begin
			bval_s1 <= bvalid_q[bm_raddr];
			idx_s1  <= bm_raddr;
		end
		sq_s2  <= 16'(b_s1) * 16'(b_s1);
		nz_s2  <= v_s1 && (b_s1 != 8'd0);
		idx_s2 <= idx_s1;
		case (state_q)
			ST_EXEC: begin
				res_q <= '0;
				if (op == OP_FLUSH) begin
					walk_q       <= '0;
					n_q          <= '0;
					off_q        <= 16'(18'(cnt_eff) << FRAME_UNIT);
					flush_bank_q <= ~live_q;
				end
				tread_q <= !at_off;
				tok_q   <= bank_ok_q[tick_bank];
				tfs_q   <= restart;
				tdflt_q <= at_off ? bank_off_q[live_q] : 16'd1;
			end
			ST_WALK: begin
				walk_q <= walk_q + POS_W'(1);
				if (slot_we) begin
					off_q <= off_q - 16'(on_t);
					n_q   <= n_q + CNT_W'(1);
				end
			end
			ST_FIN: res_q <= taken_rsp;
			ST_TICK: res_q <= dec_rsp;
			ST_RESP: begin
				if (rsp_free) rsp_q <= res_q;
			end
			default: ;
		endcase
	end

	// a bank never flushed still holds its reset slot: LED 0 with a duration of one
	always_comb begin
		view.read        = tread_q;
		view.frame_start = tfs_q;
		view.dflt        = tdflt_q;
		if (tok_q) begin
			view.in_table = (32'(smem_rd_q[SLW-1:SLOT_TIME_W]) < LINE_TABLE_SIZE);
			view.led      = smem_rd_q[SLOT_TIME_W+4:SLOT_TIME_W];
			view.on_time  = smem_rd_q[SLOT_TIME_W-1:0];
		end else begin
			view.in_table = 1'b1;
			view.led      = 5'd0;
			view.on_time  = SLOT_TIME_W'(1);
		end
	end

	lpfs_slot_decode u_decode (
		.view (view),
		.rsp  (dec_rsp)
	);

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(bank_cnt_q[live_q]) + POS_W'(1))
		else $error("slot position ran past the off-time slot");

	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(bank_cnt_q[0] != '0) && (bank_cnt_q[1] != '0))
		else $error("bank holds no slot");

	a_idle_bank_write: assert property (@(posedge clk) disable iff (!arst_n)
		slot_we |-> ((slot_waddr >= BANK1_BASE) != live_q))
		else $error("flush wrote into the live bank");

	a_swap_at_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(live_q != $past(live_q)) |-> tfs_q)
		else $error("bank swap away from a frame start");

	a_walk_not_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> !pending_q)
		else $error("flush walk while a swap is pending");

endmodule

FILE: dv/led_pwm_frame_scheduler_tb.sv
// Self-checking testbench of the LED frame scheduler with its own frame and slot predictor.
`timescale 1ns / 1ps

module led_pwm_frame_scheduler_tb;
	import lpfs_pkg::*;

	localparam int NUM_LEDS    = 31;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_WORDS = 900;
	localparam int QUIET_AFTER  = 750;
	localparam int HOLD_AFTER   = 400;

	// charlieplex wiring: line driven high and line driven low for each LED
	localparam logic [2:0] HIGH_OF [NUM_LEDS] = '{
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
		3'd6,
		3'd1, 3'd2, 3'd0, 3'd2, 3'd0, 3'd1,
		3'd4, 3'd5, 3'd3, 3'd5, 3'd3, 3'd4
	};
	localparam logic [2:0] LOW_OF [NUM_LEDS] = '{
		3'd3, 3'd3, 3'd3, 3'd0, 3'd0, 3'd0,
		3'd4, 3'd4, 3'd4, 3'd1, 3'd1, 3'd1,
		3'd5, 3'd5, 3'd5, 3'd2, 3'd2, 3'd2,
		3'd6,
		3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2,
		3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5
	};

	class frame_scoreboard;
		logic [7:0]  level [NUM_LEDS];
		logic [4:0]  slot_led [2][NUM_LEDS];
		logic [15:0] slot_time [2][NUM_LEDS];
		int          slot_total [2];
		logic [15:0] off_time [2];
		bit          live;
		bit          swap_wait;
		int          pos;
		rsp_t        owed [$];
		int          errors;

		function new();
			for (int i = 0; i < NUM_LEDS; i++) begin
				level[i] = '0;
				for (int k = 0; k < 2; k++) begin
					slot_led[k][i] = '0;
					slot_time[k][i] = '0;
				end
			end
			for (int k = 0; k < 2; k++) begin
				slot_time[k][0] = 16'd1;
				slot_total[k] = 1;
				off_time[k] = 16'd1;
			end
			live = 1'b0;
			swap_wait = 1'b0;
			pos = 0;
			errors = 0;
		endfunction

		function rsp_t predict_response(cmd_t c);
			rsp_t        r;
			int          bank;
			int          n;
			logic [15:0] off;
			logic [15:0] t;
			logic [15:0] d;
			logic [4:0]  led;
			r = '0;
			case (c.operation)
				OP_WRITE: begin
					if (c.led_select < NUM_LEDS)
						level[c.led_select] = c.brightness;
				end
				OP_FLUSH: begin
					if (!swap_wait) begin
						bank = live ? 0 : 1;
						off = (c.flush_count == 8'd0) ? 16'd1 << FRAME_UNIT
							: 16'(16'(c.flush_count) << FRAME_UNIT);
						n = 0;
						// compact lit LEDs in ascending order, clear the store
						for (int i = 0; i < NUM_LEDS; i++) begin
							if (level[i] != 8'd0) begin
								t = ((16'(level[i]) * 16'(level[i])) >> 6) + 16'd1;
								slot_led[bank][n] = 5'(i);
								slot_time[bank][n] = t;
								off = off - t;
								n++;
							end
							level[i] = '0;
						end
						if (off == 16'd0 || off > 16'(NUM_LEDS << FRAME_UNIT))
							off = 16'd1;
						if (n == 0) begin
							n = 1;
							off = DARK_DURATION;
							slot_led[bank][0] = DEBUG_LED;
							slot_time[bank][0] = '0;
						end
						off_time[bank] = off;
						slot_total[bank] = n;
						swap_wait = 1'b1;
						r.flush_accepted = 1'b1;
					end
				end
				OP_TICK: begin
					bank = live ? 1 : 0;
					d = 16'd1;
					if (pos == slot_total[bank])
						d = off_time[bank];
					if (pos > slot_total[bank]) begin
						pos = 0;
						r.frame_start = 1'b1;
						if (swap_wait) begin
							live = !live;
							swap_wait = 1'b0;
							bank = live ? 1 : 0;
						end
					end
					if (pos < slot_total[bank] && pos < NUM_LEDS) begin
						d = slot_time[bank][pos];
						if (d == 16'd0) begin
							d = DARK_DURATION;
						end else begin
							led = slot_led[bank][pos];
							r.led_on = 1'b1;
							r.lit_led = led;
							if (led < LINE_TABLE_SIZE) begin
								r.high_line = HIGH_OF[led];
								if (led != DEBUG_LED) begin
									r.low_line = LOW_OF[led];
									r.low_line_used = 1'b1;
								end
							end
						end
					end
					pos++;
					r.duration = d;
				end
				default: ;
			endcase
			return r;
		endfunction

		function void note_command(cmd_t c);
			owed.push_back(predict_response(c));
		endfunction

		function void compare_field(string field, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (owed.size() == 0) begin
				$display("%0t: word %0h arrived with nothing expected", $time, got);
				errors++;
				return;
			end
			want = owed.pop_front();
			compare_field("led_on", 16'(want.led_on), 16'(got.led_on));
			compare_field("lit_led", 16'(want.lit_led), 16'(got.lit_led));
			compare_field("high_line", 16'(want.high_line), 16'(got.high_line));
			compare_field("low_line", 16'(want.low_line), 16'(got.low_line));
			compare_field("low_line_used", 16'(want.low_line_used), 16'(got.low_line_used));
			compare_field("duration", want.duration, got.duration);
			compare_field("frame_start", 16'(want.frame_start), 16'(got.frame_start));
			compare_field("flush_accepted", 16'(want.flush_accepted), 16'(got.flush_accepted));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	frame_scoreboard sb = new();
	int  cycles = 0;
	int  counted = 0;
	bit  quiet = 1'b0;
	bit  hold_req = 1'b0;

	led_pwm_frame_scheduler #(.NUM_LEDS(NUM_LEDS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int n;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				rsp_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 10);
				rsp_stall <= 1'b1;
				repeat (n) @(negedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_command(input cmd_t c);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 10);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		sb.note_command(c);
		if (!(c.operation == OP_NONE || (c.operation == OP_WRITE && c.led_select >= NUM_LEDS)))
			counted++;
		@(negedge clk);
	endtask

	task automatic put_level(input logic [4:0] sel, input logic [7:0] b);
		cmd_t c;
		c.operation = OP_WRITE;
		c.led_select = sel;
		c.brightness = b;
		c.flush_count = 8'($urandom_range(0, 255));
		send_command(c);
	endtask

	task automatic flush_frame(input logic [7:0] count);
		cmd_t c;
		c.operation = OP_FLUSH;
		c.led_select = 5'($urandom_range(0, 31));
		c.brightness = 8'($urandom_range(0, 255));
		c.flush_count = count;
		send_command(c);
	endtask

	task automatic tick(input int reps);
		cmd_t c;
		repeat (reps) begin
			c.operation = OP_TICK;
			c.led_select = 5'($urandom_range(0, 31));
			c.brightness = 8'($urandom_range(0, 255));
			c.flush_count = 8'($urandom_range(0, 255));
			send_command(c);
		end
	endtask

	task automatic send_noise();
		cmd_t c;
		c.operation = 2'($urandom_range(0, 3));
		c.led_select = 5'($urandom_range(0, 31));
		c.brightness = 8'($urandom_range(0, 255));
		c.flush_count = 8'($urandom_range(0, 255));
		send_command(c);
	endtask

	initial begin
		cmd_t c;
		int   nw;
		bit   held;
		cmd_valid = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		held = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset frame, extremes, ignored index, debug LED, off-time wrap
		tick(3);
		put_level(5'd0, 8'd255);
		put_level(5'd30, 8'd1);
		put_level(5'd31, 8'd255);
		put_level(DEBUG_LED, 8'd128);
		flush_frame(8'd1);
		flush_frame(8'd255);
		c.operation = OP_NONE;
		c.led_select = 5'd31;
		c.brightness = 8'd255;
		c.flush_count = 8'd255;
		send_command(c);
		tick(6);
		// empty frame gives one dark slot
		flush_frame(8'd0);
		// on-times summing to exactly one frame unit force the zero off-time case
		put_level(5'd5, 8'd255);
		put_level(5'd9, 8'd20);
		tick(6);
		flush_frame(8'd1);
		tick(3);

		while (counted < RANDOM_WORDS) begin
			if (!held && counted >= HOLD_AFTER) begin
				held = 1'b1;
				hold_req = 1'b1;
			end
			quiet = (counted > QUIET_AFTER);
			if ($urandom_range(0, 9) < 8) begin
				// frame build: writes, flush, then between 1 and 40 ticks
				if ($urandom_range(0, 7) == 0) begin
					for (int i = 0; i < NUM_LEDS; i++)
						put_level(5'(i), 8'($urandom_range(0, 255)));
				end else begin
					nw = $urandom_range(0, 12);
					repeat (nw)
						put_level(5'($urandom_range(0, NUM_LEDS - 1)),
							8'($urandom_range(0, 255)));
				end
				if ($urandom_range(0, 3) == 0)
					flush_frame(8'($urandom_range(0, 255)));
				else
					flush_frame(8'($urandom_range(0, 8)));
				tick($urandom_range(1, 40));
			end else begin
				repeat ($urandom_range(1, 5))
					send_noise();
			end
		end
		cmd_valid <= 1'b0;

		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
